// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the parser RTL.
// Clocked on clk, disabled while arst_n is low; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMP(lbl, ante, cons, msg)
`define ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/dtp_pkg.sv =====
// Package for the decimal tenths parser: character codes, beat structs, helpers.
// No dependencies.
package dtp_pkg;
	localparam int TENTHS_W = 64;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_POINT = 8'h2e;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;

	typedef struct packed {
		logic [7:0] ch;
		logic       at_end;
	} dtp_item_t;

	typedef struct packed {
		logic                emit;
		logic                ok;
		logic [TENTHS_W-1:0] value;
	} dtp_res_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction
endpackage

// ===== rtl/dtp_if.sv =====
// Valid/ready channel interfaces for parser character and result beats.
// Depends on dtp_pkg.
interface dtp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       at_end;

	modport source (output valid, output ch, output at_end, input ready);
	modport sink (input valid, input ch, input at_end, output ready);
endinterface

interface dtp_out_if;
	logic                         valid;
	logic                         ready;
	logic [dtp_pkg::TENTHS_W-1:0] tenths_value;
	logic                         ok;

	modport source (output valid, output tenths_value, output ok, input ready);
	modport sink (input valid, input tenths_value, input ok, output ready);
endinterface

// ===== rtl/dtp_core.sv =====
// Parser state and per-character step logic (accumulate, point, fraction, finish).
// Depends on dtp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dtp_core #(
	parameter int VALUE_BITS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  dtp_pkg::dtp_item_t item,
	output dtp_pkg::dtp_res_t  res
);
	import dtp_pkg::*;

	localparam int PW = VALUE_BITS + 4;

	logic [VALUE_BITS-1:0] acc_q, acc_n;
	logic [3:0]            frac_q, frac_n;
	logic                  sp_q, sp_n;
	logic                  sf_q, sf_n;

	logic [3:0]    digit;
	logic [3:0]    addend;
	logic [PW-1:0] prod;
	logic          ovf;
	logic          fin_ok;

	assign digit  = item.ch[3:0];
	assign addend = sp_q ? frac_q : digit;
	// acc*10 + addend as (acc<<3) + (acc<<1) + addend
	assign prod   = PW'({acc_q, 3'b000}) + PW'({acc_q, 1'b0}) + PW'(addend);
	assign ovf    = |prod[PW-1:VALUE_BITS];
	assign fin_ok = sp_q && sf_q && !ovf;

	always_comb begin
		acc_n     = acc_q;
		frac_n    = frac_q;
		sp_n      = sp_q;
		sf_n      = sf_q;
		res.emit  = 1'b0;
		res.ok    = 1'b0;
		res.value = '0;
		priority if (item.at_end) begin
			res.emit  = 1'b1;
			res.ok    = fin_ok;
			res.value = fin_ok ? TENTHS_W'(prod[VALUE_BITS-1:0]) : '0;
		end else if (is_digit(item.ch)) begin
			if (!sp_q) begin
				if (ovf) begin
					res.emit = 1'b1;
				end else begin
					acc_n = prod[VALUE_BITS-1:0];
				end
			end else if (sf_q) begin
				res.emit = 1'b1;
			end else begin
				frac_n = digit;
				sf_n   = 1'b1;
			end
		end else if ((item.ch == CH_POINT) && !sp_q) begin
			sp_n = 1'b1;
		end else if (is_blank(item.ch)) begin
			if (sp_q) begin
				res.emit  = 1'b1;
				res.ok    = fin_ok;
				res.value = fin_ok ? TENTHS_W'(prod[VALUE_BITS-1:0]) : '0;
			end
		end else begin
			res.emit = 1'b1;
		end
		if (res.emit) begin
			acc_n  = '0;
			frac_n = '0;
			sp_n   = 1'b0;
			sf_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			frac_q <= '0;
			sp_q   <= 1'b0;
			sf_q   <= 1'b0;
		end else if (step) begin
			acc_q  <= acc_n;
			frac_q <= frac_n;
			sp_q   <= sp_n;
			sf_q   <= sf_n;
		end
	end

	`ASSERT_NXT(a_clear_after_emit, step && res.emit, (acc_q == '0) && !sp_q && !sf_q && (frac_q == '0), "state not cleared after result")
	`ASSERT_IMP(a_frac_needs_point, sf_q, sp_q, "fraction digit without point")
	`ASSERT_IMP(a_frac_range, 1'b1, frac_q <= 4'd9, "fraction digit out of range")
endmodule

// ===== rtl/decimal_tenths_parser.sv =====
// Decimal tenths parser top level: input register, step logic, result register.
// Each character beat is registered in the input stage, and its result in the result register.
// One character per cycle while the result channel does not stall (shift-add times ten update).
// arst_n clears the parser state and all valid flags; payload is not reset.
// Depends on dtp_pkg, dtp_if, dtp_core and assert_macros.svh.
`include "assert_macros.svh"

module decimal_tenths_parser #(
	parameter int VALUE_BITS = 64
) (
	input logic      clk,
	input logic      arst_n,
	dtp_in_if.sink   chars,
	dtp_out_if.source result
);
	import dtp_pkg::*;

	logic      vld_s1;
	dtp_item_t item_s1;
	dtp_res_t  res;

	logic                out_vld_q;
	logic                out_ok_q;
	logic [TENTHS_W-1:0] out_val_q;

	logic out_free;
	logic adv;

	assign out_free    = !out_vld_q || result.ready;
	assign adv         = vld_s1 && out_free;
	assign chars.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (chars.ready) begin
			vld_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			item_s1.ch     <= chars.ch;
			item_s1.at_end <= chars.at_end;
		end
	end

	dtp_core #(
		.VALUE_BITS(VALUE_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= adv && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.emit) begin
			out_ok_q  <= res.ok;
			out_val_q <= res.value;
		end
	end

	assign result.valid        = out_vld_q;
	assign result.ok           = out_ok_q;
	assign result.tenths_value = out_val_q;

	`ASSERT_NXT(a_s1_holds, vld_s1 && !out_free, vld_s1 && $stable(item_s1), "input stage lost a stalled beat")
	`ASSERT_IMP(a_err_zero, out_vld_q && !out_ok_q, out_val_q == '0, "error result carries nonzero value")
	`ASSERT_NXT(a_emit_shows, adv && res.emit, out_vld_q, "emitted result not registered")
endmodule

// ===== bench/tenths_checker.sv =====
// Checker for the decimal tenths parser: watches the character and result channels,
// predicts each result from the accepted characters and compares it field by field.
// Depends on dtp_pkg and dtp_if.
module tenths_checker #(
	parameter int VALUE_BITS = 64
) (
	input  logic clk,
	input  logic arst_n,
	dtp_in_if    chars,
	dtp_out_if   result,
	output int   errors,
	output int   pending
);
	import dtp_pkg::*;

	localparam logic [TENTHS_W-1:0] VALUE_MAX = (VALUE_BITS >= TENTHS_W) ? '1 :
		((TENTHS_W'(1) << VALUE_BITS) - TENTHS_W'(1));

	logic [TENTHS_W-1:0] int_part;
	logic [3:0]          frac;
	logic                got_point;
	logic                got_frac;
	dtp_res_t            tenths_q[$];
	int                  mismatches = 0;

	assign errors = mismatches;

	task automatic report(input string field, input logic [63:0] got_v,
			input logic [63:0] want_v);
		$display("mismatch %s: got %0d want %0d at %0t", field, got_v, want_v, $time);
		mismatches++;
	endtask

	// every result, good or bad, returns the parser to its start state
	function automatic dtp_res_t emit_number(input logic good, input logic [TENTHS_W-1:0] val);
		dtp_res_t r;
		r.emit = 1'b1;
		r.ok = good;
		r.value = good ? val : '0;
		int_part = '0;
		frac = '0;
		got_point = 1'b0;
		got_frac = 1'b0;
		return r;
	endfunction

	function automatic dtp_res_t finish_number();
		logic [TENTHS_W-1:0] f;
		f = TENTHS_W'(frac);
		if (got_point && got_frac && int_part <= VALUE_MAX / 10 &&
				int_part * 10 <= VALUE_MAX - f)
			return emit_number(1'b1, int_part * 10 + f);
		return emit_number(1'b0, '0);
	endfunction

	function automatic dtp_res_t parse_char(input logic [7:0] c, input logic fin);
		dtp_res_t r;
		logic [TENTHS_W-1:0] d;
		r = '0;
		d = TENTHS_W'(c) - TENTHS_W'(CH_ZERO);
		if (fin) begin
			r = finish_number();
		end else if (c >= CH_ZERO && c <= CH_NINE) begin
			if (!got_point) begin
				if (int_part > (VALUE_MAX - d) / 10)
					r = emit_number(1'b0, '0);
				else
					int_part = int_part * 10 + d;
			end else if (got_frac) begin
				r = emit_number(1'b0, '0);
			end else begin
				frac = d[3:0];
				got_frac = 1'b1;
			end
		end else if (c == CH_POINT && !got_point) begin
			got_point = 1'b1;
		end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
			if (got_point)
				r = finish_number();
		end else begin
			r = emit_number(1'b0, '0);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dtp_res_t want;
		dtp_res_t next_res;
		if (!arst_n) begin
			void'(emit_number(1'b0, '0));
			tenths_q.delete();
			pending = 0;
		end else begin
			// results first: a result never belongs to a character taken at the same edge
			if (result.valid && result.ready) begin
				if (tenths_q.size() == 0) begin
					report("unexpected result", result.tenths_value, '0);
				end else begin
					want = tenths_q.pop_front();
					if (result.ok !== want.ok)
						report("ok", 64'(result.ok), 64'(want.ok));
					if (result.tenths_value !== want.value)
						report("tenths_value", result.tenths_value, want.value);
				end
			end
			if (chars.valid && chars.ready) begin
				next_res = parse_char(chars.ch, chars.at_end);
				if (next_res.emit)
					tenths_q.push_back(next_res);
			end
			pending = tenths_q.size();
		end
	end
endmodule

// ===== bench/tb.sv =====
// Testbench top for the decimal tenths parser: clock, reset, character stimulus,
// result backpressure and the verdict. Depends on dtp_pkg, dtp_if, the parser
// RTL and tenths_checker.
module tb;
	import dtp_pkg::*;

	localparam int VALUE_BITS = 64;
	localparam int PHASE_BEATS = 450;

	localparam int FLAW_NONE       = 0;
	localparam int FLAW_NO_POINT   = 1;
	localparam int FLAW_NO_FRAC    = 2;
	localparam int FLAW_TWO_POINTS = 3;
	localparam int FLAW_TWO_FRACS  = 4;
	localparam int FLAW_STRAY      = 5;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   idle_pct;
	int   stall_pct;
	int   beats_sent;

	int    idle_tbl[4] = '{0, 81, 0, 20};
	int    stall_tbl[4] = '{0, 0, 81, 20};
	string top_digits = "18446744073709551615";

	dtp_item_t text_q[$];

	dtp_in_if  chars_if ();
	dtp_out_if result_if ();

	decimal_tenths_parser #(.VALUE_BITS(VALUE_BITS)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.result (result_if)
	);

	tenths_checker #(.VALUE_BITS(VALUE_BITS)) checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.result  (result_if),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		result_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			result_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic put(input logic [7:0] c);
		dtp_item_t it;
		it.ch = c;
		it.at_end = 1'b0;
		text_q.push_back(it);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endtask

	task automatic put_digit();
		put(CH_ZERO + 8'($urandom_range(9)));
	endtask

	task automatic put_blank();
		if ($urandom_range(5) == 0)
			put(CH_SPACE);
		else
			put(CH_TAB + 8'($urandom_range(4)));
	endtask

	// end marker; the character byte is ignored, so it is random
	task automatic put_end();
		dtp_item_t it;
		it.ch = 8'($urandom_range(255));
		it.at_end = 1'b1;
		text_q.push_back(it);
	endtask

	// valid stays high across back-to-back beats, lowered only for a gap
	task automatic send_beat(input logic [7:0] c, input logic fin);
		if ($urandom_range(99) < idle_pct) begin
			chars_if.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		chars_if.valid <= 1'b1;
		chars_if.ch <= c;
		chars_if.at_end <= fin;
		do
			@(posedge clk);
		while (!chars_if.ready);
		beats_sent++;
	endtask

	task automatic send_text();
		foreach (text_q[i])
			send_beat(text_q[i].ch, text_q[i].at_end);
		text_q.delete();
	endtask

	task automatic drain();
		chars_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// a fifth of the numbers carry one injected format flaw; a twentieth are random bytes instead
	task automatic build_number();
		int        kind;
		int        flaw;
		int        n;
		int        pos;
		dtp_item_t junk;
		kind = $urandom_range(99);
		flaw = (kind >= 75) ? $urandom_range(FLAW_NO_POINT, FLAW_STRAY) : FLAW_NONE;
		if (kind >= 95) begin
			repeat ($urandom_range(1, 4)) begin
				junk.ch = 8'($urandom_range(255));
				junk.at_end = ($urandom_range(9) == 0);
				text_q.push_back(junk);
			end
			return;
		end
		repeat ($urandom_range(2))
			put_blank();
		if (kind < 15) begin
			// near the 64-bit limit
			n = $urandom_range(1) ? 19 : $urandom_range(17, 18);
			for (int i = 0; i < n; i++)
				put(top_digits[i]);
			if ($urandom_range(2) == 0)
				put_digit();
		end else begin
			repeat ($urandom_range(6)) begin
				put_digit();
				if ($urandom_range(6) == 0)
					put_blank();
			end
		end
		if (flaw != FLAW_NO_POINT)
			put(CH_POINT);
		if (flaw == FLAW_TWO_POINTS)
			put(CH_POINT);
		if (flaw != FLAW_NO_FRAC) begin
			if (kind < 15 && $urandom_range(1))
				put(CH_ZERO + 8'd5);
			else
				put_digit();
		end
		if (flaw == FLAW_TWO_FRACS)
			put_digit();
		if (flaw == FLAW_STRAY) begin
			junk.ch = 8'($urandom_range(255));
			junk.at_end = 1'b0;
			pos = $urandom_range(text_q.size());
			text_q.insert(pos, junk);
		end
		if ($urandom_range(4) < 2)
			put_end();
		else
			put_blank();
	endtask

	initial begin
		chars_if.valid = 1'b0;
		chars_if.ch = '0;
		chars_if.at_end = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		beats_sent = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// empty input, zero, blanks inside the integer, double point, two fraction
		// digits, bad character, missing point, missing fraction digit
		put_end();
		put_str("0.0");
		put_end();
		put_str(" 9 9.9\t");
		put_str("1..");
		put_str("2.34");
		put_str("5x");
		put_str("7\n");
		put_end();
		put_str("8.");
		put_end();
		send_text();

		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_tbl[p];
			stall_pct = stall_tbl[p];
			while (beats_sent < (p + 1) * PHASE_BEATS) begin
				build_number();
				send_text();
				if ($urandom_range(49) == 0)
					drain();
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
